FILE: rtl/sen_pkg.sv
// Shared types, constants and single-precision helper functions for the
// scaled Euclidean norm block. No dependencies.
package sen_pkg;

    localparam logic [31:0] QNAN    = 32'h7FC0_0000;
    localparam logic [31:0] POS_INF = 32'h7F80_0000;
    localparam logic [31:0] ONE     = 32'h3F80_0000;
    localparam logic [31:0] ZERO    = 32'h0000_0000;

    typedef enum logic [1:0] {
        MUL_SSQ_R,
        MUL_T_R,
        MUL_R_R,
        MUL_SCALE_ROOT
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     load_first;
        logic     div_start;
        logic     div_swap;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     add_start;
        logic     add_one;
        logic     ssq_nan;
        logic     sqrt_start;
        logic     res_load;
        logic     res_first;
        logic     clear;
    } cmd_t;

    typedef struct packed {
        logic ax_zero;
        logic ax_nan;
        logic ax_bigger;
        logic div_done;
        logic sqrt_done;
    } sts_t;

    typedef struct packed {
        logic [23:0]        mant;
        logic signed [11:0] expo;
    } unp_t;

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    // Normalised mantissa (leading one at bit 23) and true exponent.
    function automatic unp_t unpack(input logic [31:0] x);
        unp_t       u;
        logic [4:0] lead;
        logic [4:0] sh;
        lead = 5'd0;
        sh   = 5'd0;
        if (x[30:23] != 8'd0) begin
            u.mant = {1'b1, x[22:0]};
            u.expo = $signed({4'b0, x[30:23]}) - 12'sd127;
        end else begin
            for (int i = 0; i < 23; i++) begin
                if (x[i]) lead = 5'(i);
            end
            sh     = 5'd23 - lead;
            u.mant = {1'b0, x[22:0]} << sh;
            u.expo = $signed({7'b0, lead}) - 12'sd149;
        end
        return u;
    endfunction

    // m: leading one at bit 26, bit 0 carries sticky. Value m/2^26 * 2^e.
    function automatic logic [31:0] round_pack(input logic signed [11:0] e,
                                               input logic [26:0] m);
        logic signed [11:0] be;
        logic signed [11:0] shs;
        logic [4:0]         sh;
        logic [26:0]        ms;
        logic [26:0]        mask;
        logic [7:0]         fld;
        logic [31:0]        base;
        logic               inc;
        be   = e + 12'sd127;
        shs  = 12'sd1 - be;
        sh   = 5'd0;
        mask = 27'd0;
        if (be >= 12'sd255) begin
            return POS_INF;
        end
        if (be <= 12'sd0) begin
            sh    = (shs > 12'sd26) ? 5'd27 : shs[4:0];
            mask  = (27'd1 << sh) - 27'd1;
            ms    = m >> sh;
            ms[0] = ms[0] | (|(m & mask));
            fld   = 8'd0;
        end else begin
            ms  = m;
            fld = be[7:0];
        end
        base = {1'b0, fld, ms[25:3]};
        inc  = ms[2] & ((|ms[1:0]) | ms[3]);
        return base + {31'd0, inc};
    endfunction

endpackage

FILE: rtl/sen_div.sv
// Iterative single-precision divider for non-negative operands, one quotient
// bit per cycle. Depends on sen_pkg.
module sen_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quo
);
    localparam int QUO_BITS = 27;

    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [25:0]        rem_reg, rem_next;
    logic [26:0]        q_reg, q_next;
    logic [23:0]        mb_reg, mb_next;
    logic signed [11:0] exp_reg, exp_next;
    logic [31:0]        res_reg, res_next;

    sen_pkg::unp_t ua, ub;
    logic          spec;
    logic [31:0]   sres;
    logic          nz, dz, ni, di;
    logic          ge;
    logic [25:0]   diff;

    always_comb begin
        ua   = sen_pkg::unpack(num);
        ub   = sen_pkg::unpack(den);
        nz   = num[30:0] == 31'd0;
        dz   = den[30:0] == 31'd0;
        ni   = num[30:0] == sen_pkg::POS_INF[30:0];
        di   = den[30:0] == sen_pkg::POS_INF[30:0];
        spec = sen_pkg::is_nan(num) | sen_pkg::is_nan(den) | nz | dz | ni | di;
        if (sen_pkg::is_nan(num) || sen_pkg::is_nan(den) || (ni && di) || (nz && dz)) begin
            sres = sen_pkg::QNAN;
        end else if (di || nz) begin
            sres = sen_pkg::ZERO;
        end else begin
            sres = sen_pkg::POS_INF;
        end

        ge   = rem_reg >= {2'b0, mb_reg};
        diff = ge ? rem_reg - {2'b0, mb_reg} : rem_reg;

        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        mb_next   = mb_reg;
        exp_next  = exp_reg;
        res_next  = res_reg;

        if (start) begin
            if (spec) begin
                res_next  = sres;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
                cnt_next  = 5'd0;
                rem_next  = {2'b0, ua.mant};
                mb_next   = ub.mant;
                exp_next  = ua.expo - ub.expo;
            end
        end else if (busy_reg) begin
            q_next   = {q_reg[25:0], ge};
            rem_next = {diff[24:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(QUO_BITS - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            done_next = 1'b1;
            if (q_reg[26]) begin
                res_next = sen_pkg::round_pack(exp_reg,
                                               {q_reg[26:1], q_reg[0] | (rem_reg != 26'd0)});
            end else begin
                res_next = sen_pkg::round_pack(exp_reg - 12'sd1,
                                               {q_reg[25:0], rem_reg != 26'd0});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        mb_reg  <= mb_next;
        exp_reg <= exp_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign quo  = res_reg;

endmodule

FILE: rtl/sen_sqrt.sv
// Iterative correctly rounded single-precision square root, one root bit per
// cycle. Depends on sen_pkg.
module sen_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] rad,
    output logic        done,
    output logic [31:0] root
);
    localparam int ROOT_BITS = 25;

    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [49:0]        rad_reg, rad_next;
    logic [24:0]        r_reg, r_next;
    logic [25:0]        rem_reg, rem_next;
    logic signed [11:0] exp_reg, exp_next;
    logic [31:0]        res_reg, res_next;

    sen_pkg::unp_t      u;
    logic [24:0]        m25;
    logic signed [11:0] e_even;
    logic [27:0]        cur;
    logic [27:0]        trial;
    logic               ge;
    logic [27:0]        diff;

    always_comb begin
        u = sen_pkg::unpack(rad);
        if (u.expo[0]) begin
            m25    = {u.mant, 1'b0};
            e_even = u.expo - 12'sd1;
        end else begin
            m25    = {1'b0, u.mant};
            e_even = u.expo;
        end

        cur   = {rem_reg, rad_reg[49:48]};
        trial = {1'b0, r_reg, 2'b01};
        ge    = cur >= trial;
        diff  = ge ? cur - trial : cur;

        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        r_next    = r_reg;
        rem_next  = rem_reg;
        exp_next  = exp_reg;
        res_next  = res_reg;

        if (start) begin
            if (sen_pkg::is_nan(rad)) begin
                res_next  = sen_pkg::QNAN;
                done_next = 1'b1;
            end else if (rad[30:0] == 31'd0) begin
                res_next  = rad;
                done_next = 1'b1;
            end else if (rad[31]) begin
                res_next  = sen_pkg::QNAN;
                done_next = 1'b1;
            end else if (rad[30:23] == 8'hFF) begin
                res_next  = rad;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
                cnt_next  = 5'd0;
                rad_next  = {m25, 25'd0};
                r_next    = 25'd0;
                rem_next  = 26'd0;
                exp_next  = e_even >>> 1;
            end
        end else if (busy_reg) begin
            rad_next = {rad_reg[47:0], 2'b00};
            r_next   = {r_reg[23:0], ge};
            rem_next = diff[25:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(ROOT_BITS - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            done_next = 1'b1;
            res_next  = sen_pkg::round_pack(exp_reg, {r_reg, rem_reg != 26'd0, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rad_reg <= rad_next;
        r_reg   <= r_next;
        rem_reg <= rem_next;
        exp_reg <= exp_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

FILE: rtl/sen_dpath.sv
// Datapath: scale, sum and temporaries, two-stage multiplier, adder and the
// divide and square-root units. Depends on sen_pkg, sen_div, sen_sqrt.
module sen_dpath (
    input  logic          aclk,
    input  logic          aresetn,
    input  sen_pkg::cmd_t cmd,
    input  logic [31:0]   in_bits,
    output sen_pkg::sts_t sts,
    output logic [31:0]   result
);
    logic [31:0]        ax_reg, scale_reg, ssq_reg, r_reg, t_reg, first_reg, res_reg;
    logic [47:0]        p_reg;
    logic signed [11:0] pe_reg;
    logic               mspec_reg;
    logic [31:0]        msres_reg;
    logic               mwb_reg;

    logic [31:0] div_num, div_den, div_q, root_bits;
    logic        div_done, sqrt_done;

    // Sum of two non-negative values; NaN and infinity pass through.
    function automatic logic [31:0] add_pos(input logic [31:0] x, input logic [31:0] y);
        logic [31:0]        a;
        logic [31:0]        b;
        sen_pkg::unp_t      ua;
        sen_pkg::unp_t      ub;
        logic signed [11:0] d;
        logic [4:0]         sh;
        logic [26:0]        bw;
        logic [26:0]        bs;
        logic [26:0]        mask;
        logic [27:0]        sum;
        if (sen_pkg::is_nan(x) || sen_pkg::is_nan(y)) return sen_pkg::QNAN;
        if (x[30:23] == 8'hFF || y[30:23] == 8'hFF) return sen_pkg::POS_INF;
        if (y[30:0] > x[30:0]) begin
            a = y;
            b = x;
        end else begin
            a = x;
            b = y;
        end
        if (b[30:0] == 31'd0) return a;
        ua    = sen_pkg::unpack(a);
        ub    = sen_pkg::unpack(b);
        d     = ua.expo - ub.expo;
        sh    = (d > 12'sd26) ? 5'd27 : d[4:0];
        bw    = {ub.mant, 3'b000};
        mask  = (27'd1 << sh) - 27'd1;
        bs    = bw >> sh;
        bs[0] = bs[0] | (|(bw & mask));
        sum   = {1'b0, ua.mant, 3'b000} + {1'b0, bs};
        if (sum[27]) begin
            return sen_pkg::round_pack(ua.expo + 12'sd1, {sum[27:2], |sum[1:0]});
        end
        return sen_pkg::round_pack(ua.expo, sum[26:0]);
    endfunction

    logic [31:0]   ma, mb;
    sen_pkg::unp_t uma, umb;
    logic          m_nan, m_ai, m_bi, m_az, m_bz;
    logic [31:0]   m_sres;
    logic [31:0]   mul_round;

    always_comb begin
        case (cmd.mul_sel)
            sen_pkg::MUL_SSQ_R: begin
                ma = ssq_reg;
                mb = r_reg;
            end
            sen_pkg::MUL_T_R: begin
                ma = t_reg;
                mb = r_reg;
            end
            sen_pkg::MUL_R_R: begin
                ma = r_reg;
                mb = r_reg;
            end
            sen_pkg::MUL_SCALE_ROOT: begin
                ma = scale_reg;
                mb = root_bits;
            end
            default: begin
                ma = r_reg;
                mb = r_reg;
            end
        endcase
        uma   = sen_pkg::unpack(ma);
        umb   = sen_pkg::unpack(mb);
        m_nan = sen_pkg::is_nan(ma) | sen_pkg::is_nan(mb);
        m_ai  = ma[30:0] == sen_pkg::POS_INF[30:0];
        m_bi  = mb[30:0] == sen_pkg::POS_INF[30:0];
        m_az  = ma[30:0] == 31'd0;
        m_bz  = mb[30:0] == 31'd0;
        if (m_nan) begin
            m_sres = sen_pkg::QNAN;
        end else if (m_ai || m_bi) begin
            m_sres = (m_az || m_bz) ? sen_pkg::QNAN : sen_pkg::POS_INF;
        end else begin
            m_sres = sen_pkg::ZERO;
        end
        if (p_reg[47]) begin
            mul_round = sen_pkg::round_pack(pe_reg + 12'sd1, {p_reg[47:22], |p_reg[21:0]});
        end else begin
            mul_round = sen_pkg::round_pack(pe_reg, {p_reg[46:21], |p_reg[20:0]});
        end
    end

    assign div_num = cmd.div_swap ? scale_reg : ax_reg;
    assign div_den = cmd.div_swap ? ax_reg : scale_reg;

    sen_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    sen_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .rad     (ssq_reg),
        .done    (sqrt_done),
        .root    (root_bits)
    );

    logic [31:0] res_pick;
    assign res_pick = cmd.res_first ? first_reg : t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= sen_pkg::ZERO;
            ssq_reg   <= sen_pkg::ONE;
            first_reg <= sen_pkg::ZERO;
            mwb_reg   <= 1'b0;
        end else begin
            mwb_reg <= cmd.mul_start;
            if (cmd.load && cmd.load_first) begin
                first_reg <= {1'b0, in_bits[30:0]};
            end
            if (cmd.clear) begin
                scale_reg <= sen_pkg::ZERO;
                ssq_reg   <= sen_pkg::ONE;
            end else if (cmd.ssq_nan) begin
                ssq_reg <= sen_pkg::QNAN;
            end else if (cmd.add_start) begin
                ssq_reg <= add_pos(cmd.add_one ? sen_pkg::ONE : ssq_reg, t_reg);
                if (cmd.add_one) begin
                    scale_reg <= ax_reg;
                end
            end
        end
        if (cmd.load) begin
            ax_reg <= {1'b0, in_bits[30:0]};
        end
        if (div_done) begin
            r_reg <= div_q;
        end
        if (cmd.mul_start) begin
            p_reg     <= uma.mant * umb.mant;
            pe_reg    <= uma.expo + umb.expo;
            mspec_reg <= m_nan | m_ai | m_bi | m_az | m_bz;
            msres_reg <= m_sres;
        end
        if (mwb_reg) begin
            t_reg <= mspec_reg ? msres_reg : mul_round;
        end
        if (cmd.res_load) begin
            res_reg <= sen_pkg::is_nan(res_pick) ? sen_pkg::QNAN : res_pick;
        end
    end

    assign sts.ax_zero   = ax_reg[30:0] == 31'd0;
    assign sts.ax_nan    = sen_pkg::is_nan(ax_reg);
    assign sts.ax_bigger = ax_reg[30:0] > scale_reg[30:0];
    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sqrt_done;
    assign result        = res_reg;

endmodule

FILE: rtl/sen_ctrl.sv
// Controller: sequences one element at a time through the datapath and
// holds the result handshake. Depends on sen_pkg.
module sen_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tlast,
    input  logic          m_tready,
    input  sen_pkg::sts_t sts,
    output sen_pkg::cmd_t cmd,
    output logic          s_tready,
    output logic          m_tvalid
);
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV_WAIT,
        ST_MUL1,
        ST_MUL1_WAIT,
        ST_MUL2,
        ST_MUL2_WAIT,
        ST_ADD,
        ST_TAIL,
        ST_SQRT_WAIT,
        ST_MULN,
        ST_MULN_WAIT,
        ST_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic       last_reg, last_next;
    logic       big_reg, big_next;
    logic       first_sel_reg, first_sel_next;
    logic [1:0] count_reg, count_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        last_next      = last_reg;
        big_next       = big_reg;
        first_sel_next = first_sel_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.mul_sel    = sen_pkg::MUL_R_R;
        cmd.res_first  = first_sel_reg;
        cmd.add_one    = big_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load       = 1'b1;
                    cmd.load_first = count_reg == 2'd0;
                    last_next      = s_tlast;
                    count_next     = (count_reg == 2'd2) ? 2'd2 : count_reg + 2'd1;
                    state_next     = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                big_next = sts.ax_bigger;
                if (sts.ax_zero) begin
                    state_next = ST_TAIL;
                end else if (sts.ax_nan) begin
                    cmd.ssq_nan = 1'b1;
                    state_next  = ST_TAIL;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_swap  = sts.ax_bigger;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = big_reg ? sen_pkg::MUL_SSQ_R : sen_pkg::MUL_R_R;
                state_next    = ST_MUL1_WAIT;
            end
            ST_MUL1_WAIT: begin
                state_next = big_reg ? ST_MUL2 : ST_ADD;
            end
            ST_MUL2: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = sen_pkg::MUL_T_R;
                state_next    = ST_MUL2_WAIT;
            end
            ST_MUL2_WAIT: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add_start = 1'b1;
                state_next    = ST_TAIL;
            end
            ST_TAIL: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (count_reg == 2'd1) begin
                    first_sel_next = 1'b1;
                    state_next     = ST_FIN;
                end else begin
                    first_sel_next = 1'b0;
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT: begin
                if (sts.sqrt_done) state_next = ST_MULN;
            end
            ST_MULN: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = sen_pkg::MUL_SCALE_ROOT;
                state_next    = ST_MULN_WAIT;
            end
            ST_MULN_WAIT: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.res_load   = 1'b1;
                    cmd.clear      = 1'b1;
                    count_next     = 2'd0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            big_reg       <= 1'b0;
            first_sel_reg <= 1'b0;
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            big_reg       <= big_next;
            first_sel_reg <= first_sel_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/scaled_euclidean_norm.sv
// Top level of the scaled Euclidean norm block: stream ports, controller and
// datapath. Depends on sen_pkg, sen_ctrl, sen_dpath.
//
// Streams a vector of IEEE single-precision elements, one per input
// transaction, with s_tlast on the final one, and returns its Euclidean norm
// as one result transaction per vector, computed as scale*sqrt(ssq) with a
// running maximum magnitude as scale so that no intermediate overflows. A
// one-element vector returns the element's magnitude; any NaN result comes
// out as 0x7FC00000. Elements are taken one at a time: each passes accept,
// decision and tail; any element that is neither an exact zero nor a NaN
// also runs the bit-serial divider, the two-stage multiplier (once, or twice
// when it raises the scale) and the adder. When either divide operand is
// zero or infinite, as for the first non-zero element, the divide skips the
// bit-serial iteration. The last element adds the bit-serial square root,
// the final multiply and the result hand-off; a one-element vector adds only
// the hand-off. The result sits in an output register, so the next vector is
// accepted while it waits; the block only stalls if a second result is ready
// before the first has been taken.
module scaled_euclidean_norm (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [31:0] element_bits
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [31:0] norm_bits
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);
    sen_pkg::cmd_t cmd;
    sen_pkg::sts_t sts;

    // Sequence each transaction through divide, multiply and add steps.
    sen_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    // Hold scale, scaled sum and the result register.
    sen_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_bits (s_tdata),
        .sts     (sts),
        .result  (m_tdata)
    );

endmodule

FILE: rtl/sen_checker.sv
// Port-level checks for the scaled Euclidean norm block, bound to the top
// level. Depends on scaled_euclidean_norm.
module sen_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // Take one element at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // No result may appear straight after an element transaction.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // Drop any pending result on reset.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind scaled_euclidean_norm sen_checker u_sen_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
